/* rtl/hws_pkg.sv */
package hws_pkg;

  // Defaults for the top-level parameters
  localparam int HWS_TASKS      = 9;
  localparam int HWS_RING_DEPTH = 8;
  localparam int TASK_MAX       = 16;
  localparam int RING_MAX       = 32;

  // Ring count travels at a fixed width that covers the deepest ring
  localparam int CNT_W  = $clog2(RING_MAX + 1);
  localparam int MASK_W = 9;
  localparam int WIN_W  = 4;
  localparam int ADDR_W = 5;

  // Register reset values
  localparam logic [31:0] RST_STALL_LIMIT = 32'd30000;
  localparam logic [31:0] RST_LOW_HEAP    = 32'd20000;
  localparam logic [15:0] RST_TICK_PERIOD = 16'd1000;
  localparam logic [15:0] RST_LOOP_WINDOW = 16'd60;
  localparam logic [5:0]  RST_LOOP_COUNT  = 6'd3;
  localparam logic        RST_STORAGE_OK  = 1'b0;

  localparam logic [WIN_W-1:0] WIN_SAT = 4'd15;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_BOOT      = 2'd2,
    CMD_SENSOR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    HS_HEALTHY  = 2'd0,
    HS_WARNING  = 2'd1,
    HS_DEGRADED = 2'd2,
    HS_FAILED   = 2'd3
  } health_t;

  localparam logic [1:0] ALARM_NONE = 2'd0;
  localparam logic [1:0] ALARM_WARN = 2'd1;

  typedef enum logic [2:0] {
    REG_STALL_LIMIT = 3'd0,
    REG_LOW_HEAP    = 3'd1,
    REG_TICK_PERIOD = 3'd2,
    REG_LOOP_WINDOW = 3'd3,
    REG_LOOP_COUNT  = 3'd4,
    REG_STORAGE_OK  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HB_SCAN,
    ST_RING_SCAN,
    ST_DONE
  } fsm_t;

  // Scan token plus running in-window count handed along the ring chain
  typedef struct packed {
    logic             tok;
    logic [CNT_W-1:0] cnt;
  } ring_link_t;

endpackage

/* rtl/health_watchdog_supervisor.sv */
// Heartbeat watchdog and boot-loop supervisor.
// Input channel (in_*): one command per transaction - tick, heartbeat, boot
//   record or sensor health update. Every accepted transaction yields exactly
//   one result transaction on the output channel (out_*) with the current
//   system state, stall mask, boot-loop flag, boots-in-window count and an
//   evaluated flag that is set only for a tick that passed the period gate.
// Configuration: APB-style write/read port, 32-bit registers at 4*index.
//   Write only while no command is in flight.
// Timing: one command at a time. Heartbeat, sensor update, gated tick and
//   a boot record with an unsynced clock pass from accept through EXEC and
//   DONE to the result. An evaluated tick adds a scan between: a scan token
//   walks the chain of heartbeat cells, one cell per cycle. A boot record
//   adds a ring scan: the token walks the ring cells carrying the in-window
//   count. The next command is taken in the cycle after the result is loaded.
// Stall: the result register holds while out_stall is high; a new command may
//   still be accepted and runs until its own result would overwrite it.
// Reset (synchronous, rst_n low): all heartbeats never heard, ring empty,
//   flags and state cleared, registers back to their default values.
module health_watchdog_supervisor
  import hws_pkg::*;
#(
  parameter int TASKS      = HWS_TASKS,
  parameter int RING_DEPTH = HWS_RING_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // APB-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_now_ms,
  input  logic [3:0]         in_task_id,
  input  logic [1:0]         in_sensor_index,
  input  logic               in_sensor_fault,
  input  logic [31:0]        in_unix_time,
  input  logic               in_reset_watchdog,
  input  logic [1:0]         in_highest_alarm,
  input  logic [31:0]        in_free_heap,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_system_state,
  output logic [MASK_W-1:0]  out_stall_mask,
  output logic               out_boot_loop,
  output logic [WIN_W-1:0]   out_boots_in_window,
  output logic               out_evaluated
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  // ---------------------------------------------------------------- config
  logic [31:0] stall_limit_r;
  logic [31:0] low_heap_r;
  logic [15:0] tick_period_r;
  logic [15:0] loop_window_r;
  logic [5:0]  loop_count_r;
  logic        storage_ok_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r <= RST_STALL_LIMIT;
      low_heap_r    <= RST_LOW_HEAP;
      tick_period_r <= RST_TICK_PERIOD;
      loop_window_r <= RST_LOOP_WINDOW;
      loop_count_r  <= RST_LOOP_COUNT;
      storage_ok_r  <= RST_STORAGE_OK;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STALL_LIMIT: stall_limit_r <= pwdata;
        REG_LOW_HEAP:    low_heap_r    <= pwdata;
        REG_TICK_PERIOD: tick_period_r <= pwdata[15:0];
        REG_LOOP_WINDOW: loop_window_r <= pwdata[15:0];
        REG_LOOP_COUNT:  loop_count_r  <= pwdata[5:0];
        REG_STORAGE_OK:  storage_ok_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STALL_LIMIT: prdata = stall_limit_r;
      REG_LOW_HEAP:    prdata = low_heap_r;
      REG_TICK_PERIOD: prdata = {16'd0, tick_period_r};
      REG_LOOP_WINDOW: prdata = {16'd0, loop_window_r};
      REG_LOOP_COUNT:  prdata = {26'd0, loop_count_r};
      REG_STORAGE_OK:  prdata = {31'd0, storage_ok_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- command latch
  cmd_t        cmd_r;
  logic [31:0] now_r;
  logic [3:0]  task_id_r;
  logic [1:0]  sensor_idx_r;
  logic        sensor_fault_r;
  logic [31:0] unix_r;
  logic        wdt_r;
  logic [1:0]  alarm_r;
  logic [31:0] heap_r;

  logic accept;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r          <= cmd_t'(in_command);
      now_r          <= in_now_ms;
      task_id_r      <= in_task_id;
      sensor_idx_r   <= in_sensor_index;
      sensor_fault_r <= in_sensor_fault;
      unix_r         <= in_unix_time;
      wdt_r          <= in_reset_watchdog;
      alarm_r        <= in_highest_alarm;
      heap_r         <= in_free_heap;
    end
  end

  // ------------------------------------------------------------ sequencer
  fsm_t state_r, state_nxt;

  logic hb_done, ring_done;
  logic gate_ok;
  logic tick_go, hb_wr, ring_wr, ring_go, boot_zero, sensor_upd;
  logic hb_fin, ring_fin, out_load;

  logic [31:0] last_tick_r;
  logic [31:0] since_tick;

  assign since_tick = now_r - last_tick_r;
  assign gate_ok    = since_tick >= {16'd0, tick_period_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (tick_go)      state_nxt = ST_HB_SCAN;
        else if (ring_go) state_nxt = ST_RING_SCAN;
        else              state_nxt = ST_DONE;
      end
      ST_HB_SCAN: begin
        if (hb_done) state_nxt = ST_DONE;
      end
      ST_RING_SCAN: begin
        if (ring_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    accept     = in_valid && (state_r == ST_IDLE);
    tick_go    = (state_r == ST_EXEC) && (cmd_r == CMD_TICK) && gate_ok;
    hb_wr      = (state_r == ST_EXEC) && (cmd_r == CMD_HEARTBEAT);
    ring_wr    = (state_r == ST_EXEC) && (cmd_r == CMD_BOOT);
    ring_go    = ring_wr && (unix_r != 32'd0);
    boot_zero  = ring_wr && (unix_r == 32'd0);
    sensor_upd = (state_r == ST_EXEC) && (cmd_r == CMD_SENSOR);
    hb_fin     = (state_r == ST_HB_SCAN) && hb_done;
    ring_fin   = (state_r == ST_RING_SCAN) && ring_done;
    out_load   = (state_r == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // --------------------------------------------------- heartbeat cell chain
  logic             hb_start_r;
  logic [TASKS-1:0] hb_tok;
  logic [TASKS-1:0] stall_flags;

  for (genvar i = 0; i < TASKS; i++) begin : g_hb
    hws_hb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (hb_wr && (task_id_r == 4'(i))),
      .wr_time (now_r),
      .now     (now_r),
      .limit   (stall_limit_r),
      .tok_in  ((i == 0) ? hb_start_r : hb_tok[(i == 0) ? 0 : i-1]),
      .tok_out (hb_tok[i]),
      .stalled (stall_flags[i])
    );
  end

  assign hb_done = hb_tok[TASKS-1];

  // -------------------------------------------------------- ring cell chain
  logic                  ring_start_r;
  logic [PTR_W-1:0]      ring_ptr_r;
  ring_link_t            ring_head;
  ring_link_t            ring_link [RING_DEPTH];

  assign ring_head.tok = ring_start_r;
  assign ring_head.cnt = '0;

  for (genvar j = 0; j < RING_DEPTH; j++) begin : g_ring
    hws_ring_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (ring_wr && (ring_ptr_r == PTR_W'(j))),
      .stamp    (unix_r),
      .window   (loop_window_r),
      .link_in  ((j == 0) ? ring_head : ring_link[(j == 0) ? 0 : j-1]),
      .link_out (ring_link[j])
    );
  end

  assign ring_done = ring_link[RING_DEPTH-1].tok;

  // ------------------------------------------------------ rollup and flags
  logic [3:0]       fault_mask_r;
  logic [1:0]       wdt_hist_r;
  logic             loop_flag_r;
  health_t          health_r;
  logic [WIN_W-1:0] win_cnt_r;
  logic             eval_r;

  logic [CNT_W-1:0] ring_cnt;
  logic [5:0]       need;
  logic             wdt_loop;
  logic             alarm_crit, alarm_warn;
  health_t          health_nxt;

  assign ring_cnt = ring_link[RING_DEPTH-1].cnt;
  // a zero loop count behaves as one
  assign need     = (loop_count_r == 6'd0) ? 6'd1 : loop_count_r;
  assign wdt_loop = wdt_r && (wdt_hist_r == 2'b11);

  // alarm codes two and three count as critical; low heap lifts none to warning
  assign alarm_crit = alarm_r[1];
  assign alarm_warn = (alarm_r == ALARM_WARN) ||
                      ((alarm_r == ALARM_NONE) && (heap_r < low_heap_r));

  always_comb begin
    if (loop_flag_r || !storage_ok_r || alarm_crit) begin
      health_nxt = HS_FAILED;
    end else if ((fault_mask_r != 4'd0) || (stall_flags != '0)) begin
      health_nxt = HS_DEGRADED;
    end else if (alarm_warn) begin
      health_nxt = HS_WARNING;
    end else begin
      health_nxt = HS_HEALTHY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_start_r   <= 1'b0;
      ring_start_r <= 1'b0;
      ring_ptr_r   <= '0;
      last_tick_r  <= '0;
      fault_mask_r <= '0;
      wdt_hist_r   <= '0;
      loop_flag_r  <= 1'b0;
      health_r     <= HS_HEALTHY;
      win_cnt_r    <= '0;
      eval_r       <= 1'b0;
    end else begin
      hb_start_r   <= tick_go;
      ring_start_r <= ring_go;
      if (state_r == ST_EXEC) begin
        eval_r <= tick_go;
      end
      if (tick_go) begin
        last_tick_r <= now_r;
      end
      if (sensor_upd) begin
        fault_mask_r[sensor_idx_r] <= sensor_fault_r;
      end
      if (ring_wr) begin
        ring_ptr_r <= (ring_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ring_ptr_r + 1'b1;
      end
      if (hb_fin) begin
        health_r <= health_nxt;
      end
      // unsynced clock: stamp stored, nothing counted
      if (boot_zero) begin
        win_cnt_r   <= '0;
        loop_flag_r <= loop_flag_r || wdt_loop;
        wdt_hist_r  <= {wdt_hist_r[0], wdt_r};
      end
      if (ring_fin) begin
        win_cnt_r   <= (ring_cnt > CNT_W'(WIN_SAT)) ? WIN_SAT : ring_cnt[WIN_W-1:0];
        loop_flag_r <= loop_flag_r || (ring_cnt >= need) || wdt_loop;
        wdt_hist_r  <= {wdt_hist_r[0], wdt_r};
      end
    end
  end

  // ------------------------------------------------------- result register
  logic [TASK_MAX-1:0] stall_wide;

  assign stall_wide = TASK_MAX'(stall_flags);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_system_state    <= health_r;
      out_stall_mask      <= stall_wide[MASK_W-1:0];
      out_boot_loop       <= loop_flag_r;
      out_boots_in_window <= win_cnt_r;
      out_evaluated       <= eval_r;
    end
  end

endmodule

/* rtl/hws_hb_cell.sv */
module hws_hb_cell
  import hws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [31:0] wr_time,
  input  logic [31:0] now,
  input  logic [31:0] limit,
  input  logic        tok_in,
  output logic        tok_out,
  output logic        stalled
);

  logic [31:0] time_r;
  logic        stall_r, stall_nxt;
  logic        tok_r;
  logic [31:0] age;

  assign age       = now - time_r;
  // zero time means never heard
  assign stall_nxt = (time_r != 32'd0) && (age > limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      stall_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (wr_en) begin
        time_r <= wr_time;
      end
      if (tok_in) begin
        stall_r <= stall_nxt;
      end
    end
  end

  assign tok_out = tok_r;
  assign stalled = stall_r;

endmodule

/* rtl/hws_ring_cell.sv */
module hws_ring_cell
  import hws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [31:0] stamp,
  input  logic [15:0] window,
  input  ring_link_t  link_in,
  output ring_link_t  link_out
);

  logic [31:0] slot_r;
  logic        tok_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0] delta;
  logic        hit;

  assign delta = stamp - slot_r;
  // empty slots never count
  assign hit  = (slot_r != 32'd0) && (delta < {16'd0, window});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= link_in.tok;
      if (wr_en) begin
        slot_r <= stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.tok) begin
      cnt_r <= link_in.cnt + CNT_W'(hit);
    end
  end

  assign link_out.tok = tok_r;
  assign link_out.cnt = cnt_r;

endmodule

/* rtl/hws_checker.sv */
module hws_checker
  import hws_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_system_state,
  input logic [MASK_W-1:0] out_stall_mask,
  input logic              out_boot_loop,
  input logic [WIN_W-1:0]  out_boots_in_window,
  input logic              out_evaluated
);

  // one command in flight: an accepted transaction blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted while another is in flight");

  // held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_system_state) &&
      $stable(out_stall_mask) && $stable(out_boot_loop) &&
      $stable(out_boots_in_window) && $stable(out_evaluated))
    else $error("stalled result changed");

  // boot loop flag is sticky
  a_loop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_boot_loop |=> out_boot_loop)
    else $error("boot loop flag cleared");

  // an evaluated tick during a boot loop reports failed
  a_loop_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evaluated && out_boot_loop |-> out_system_state == HS_FAILED)
    else $error("boot loop not rolled up into failed state");

endmodule

bind health_watchdog_supervisor hws_checker u_hws_checker (.*);
